### rtl/hpout_pkg.sv
// Package for the hashed per-object update throttle.
// Holds widths, constants, codes, the slot entry type and the hash pre-mix.
// No dependencies.
`default_nettype none

package hpout_pkg;

   localparam int SLOT_COUNT_LOG2_DEF = 8;

   localparam int KEY_W   = 32;
   localparam int FRAME_W = 32;
   localparam int ID_W    = 64;
   localparam int DT_W    = 20;
   localparam int TIME_W  = 24;
   localparam int COUNT_W = 16;
   localparam int IV_W    = 4;
   localparam int DEC_W   = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // request tdata layout, lowest bit first
   localparam int REQ_KEY_LSB   = 0;
   localparam int REQ_FRAME_LSB = REQ_KEY_LSB + KEY_W;
   localparam int REQ_OID_LSB   = REQ_FRAME_LSB + FRAME_W;
   localparam int REQ_TID_LSB   = REQ_OID_LSB + ID_W;
   localparam int REQ_DT_LSB    = REQ_TID_LSB + ID_W;
   localparam int REQ_FIELDS_W  = REQ_DT_LSB + DT_W;
   localparam int REQ_TDATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int RSP_RUN_LSB   = 0;
   localparam int RSP_TIME_LSB  = RSP_RUN_LSB + 1;
   localparam int RSP_DEC_LSB   = RSP_TIME_LSB + TIME_W;
   localparam int RSP_CROWD_LSB = RSP_DEC_LSB + DEC_W;
   localparam int RSP_FIELDS_W  = RSP_CROWD_LSB + 1;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [KEY_W-1:0]   KEY_LOW   = 32'h0001_0000;
   localparam logic [KEY_W-1:0]   KEY_HIGH  = 32'hFFE0_0000;
   localparam logic [31:0]        HASH_MULT = 32'h7FEB_352D;
   localparam int                 HASH_SHIFT_PRE  = 16;
   localparam int                 HASH_SHIFT_POST = 15;
   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [COUNT_W-1:0] CROWD_THRESHOLD_RST   = 16'd8;
   localparam logic [COUNT_W-1:0] HEAVY_CROWD_COUNT_RST = 16'd20;
   localparam logic [IV_W-1:0]    LIGHT_INTERVAL_RST    = 4'd2;
   localparam logic [IV_W-1:0]    HEAVY_INTERVAL_RST    = 4'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_CROWD_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAVY_CROWD_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_INTERVAL    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAVY_INTERVAL    = 2'd3;

   typedef enum logic [DEC_W-1:0] {
      DEC_INVALID = 3'd0,
      DEC_FULL    = 3'd1,
      DEC_FIRST   = 3'd2,
      DEC_DUE     = 3'd3,
      DEC_SKIP    = 3'd4
   } decision_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_MUL,
      S_READ,
      S_CHECK,
      S_MOD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [FRAME_W-1:0] frame;
      logic [TIME_W-1:0]  banked;
   } slot_type;

   function automatic logic [31:0] hash_premix(input logic [31:0] x);
      hash_premix = x ^ (x >> HASH_SHIFT_PRE);
   endfunction

endpackage

`default_nettype wire

### rtl/hashed_per_object_update_throttle.sv
// Top level of the hashed per-object update throttle.
// Uses hpout_pkg; holds the sequencer, the shared hash multiplier, the
// remainder unit and the direct-mapped slot memory.
//
//   channel | direction | ports                          | moves
//   req     | in        | req_tvalid/tready/tdata        | one update request
//   rsp     | out       | rsp_tvalid/tready/tdata        | one decision per request
//   csr     | in        | csr_valid/ready/index/data     | register write, always ready
//
// Path per request: S_EVAL, S_OUT for an invalid key or full-rate pass; a due or
// skipped object adds S_MUL, S_READ, S_CHECK, a first sight S_MOD; S_OUT may stall.
// The hash multiplier is used twice per table access; the remainder unit
// takes one bit of the hash per cycle.
// After reset the slot memory is cleared, one slot a cycle, through all
// 2**SLOT_COUNT_LOG2 slots; requests wait, register writes are taken.
// One request is in flight at a time; req_tready is low until its response
// has been taken.
`default_nettype none

module hashed_per_object_update_throttle #(
   parameter int SLOT_COUNT_LOG2 = hpout_pkg::SLOT_COUNT_LOG2_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // object_key, frame_number, object_id, target_id, elapsed_time, zero pad
   input  wire logic [hpout_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // run_update, update_time, decision, crowded_now, zero pad
   output      logic [hpout_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [hpout_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hpout_pkg::CSR_DATA_W-1:0]   csr_data
);

   import hpout_pkg::*;

   localparam int NUM_SLOTS = 1 << SLOT_COUNT_LOG2;
   localparam int BIT_CNT_W  = (SLOT_COUNT_LOG2 > 1) ? $clog2(SLOT_COUNT_LOG2) : 1;

   state_type state_ff, state_in;

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [ID_W-1:0]    oid_ff, oid_in;
   logic [ID_W-1:0]    tid_ff, tid_in;
   logic [DT_W-1:0]    dt_ff, dt_in;

   logic [FRAME_W-1:0] last_frame_ff, last_frame_in;
   logic [COUNT_W-1:0] cnt_this_ff, cnt_this_in;
   logic [COUNT_W-1:0] cnt_last_ff, cnt_last_in;
   logic               crowded_ff, crowded_in;

   logic [COUNT_W-1:0] thresh_ff;
   logic [COUNT_W-1:0] heavy_cnt_ff;
   logic [IV_W-1:0]    light_iv_ff;
   logic [IV_W-1:0]    heavy_iv_ff;

   logic [IV_W-1:0]            interval_ff, interval_in;
   logic [31:0]                mul_ff, mul_in;
   logic [SLOT_COUNT_LOG2-1:0] slot_idx_ff, slot_idx_in;
   logic [SLOT_COUNT_LOG2-1:0] num_ff, num_in;
   logic [IV_W-1:0]            rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [SLOT_COUNT_LOG2-1:0] clr_ff, clr_in;

   logic              run_ff, run_in;
   logic [TIME_W-1:0] time_ff, time_in;
   decision_type      dec_ff, dec_in;

   slot_type                   slot_mem [NUM_SLOTS];
   slot_type                   rd_ff;
   logic                       rd_en;
   logic                       mem_we;
   logic [SLOT_COUNT_LOG2-1:0] mem_waddr;
   logic [SLOT_COUNT_LOG2-1:0] mem_raddr;
   slot_type                   mem_wdata;

   logic                 key_valid;
   logic                 roll;
   logic [COUNT_W-1:0]   cnt_last_new;
   logic                 crowd_new;
   logic [COUNT_W-1:0]   cnt_base;
   logic                 is_target;
   logic [IV_W-1:0]      iv_sel;
   logic [IV_W-1:0]      iv_eff;
   logic [31:0]          mix;
   logic [31:0]          product;
   logic [31:0]          hash_post;
   logic [SLOT_COUNT_LOG2-1:0] hash_idx;
   logic [FRAME_W-1:0]   gap;
   logic [TIME_W:0]      bank_sum;
   logic [TIME_W-1:0]    bank_sat;
   logic [IV_W:0]        trial;
   logic [IV_W-1:0]      rem_step;

   assign key_valid    = (key_ff >= KEY_LOW) && (key_ff < KEY_HIGH);
   assign roll         = frame_ff != last_frame_ff;
   assign cnt_last_new = roll ? cnt_this_ff : cnt_last_ff;
   assign crowd_new    = roll ? (cnt_this_ff >= thresh_ff) : crowded_ff;
   assign cnt_base     = roll ? '0 : cnt_this_ff;
   assign is_target    = (oid_ff != '0) && (oid_ff == tid_ff);
   assign iv_sel       = (cnt_last_new >= heavy_cnt_ff) ? heavy_iv_ff : light_iv_ff;
   assign iv_eff       = (iv_sel == '0) ? IV_W'(1) : iv_sel;

   // shared multiplier: key hash first, inverted-key hash second
   assign mix       = (state_ff == S_MUL) ? hash_premix(key_ff) : hash_premix(~key_ff);
   assign product   = mix * HASH_MULT;
   assign hash_post = mul_ff ^ (mul_ff >> HASH_SHIFT_POST);
   assign hash_idx  = hash_post[SLOT_COUNT_LOG2-1:0];

   assign gap      = frame_ff - rd_ff.frame;
   assign bank_sum = {1'b0, rd_ff.banked} + (TIME_W + 1)'(dt_ff);
   assign bank_sat = bank_sum[TIME_W] ? TIME_MAX : bank_sum[TIME_W-1:0];

   // restoring remainder, one hash bit per cycle, MSB first
   assign trial    = {rem_ff, num_ff[SLOT_COUNT_LOG2-1]};
   assign rem_step = (trial >= {1'b0, interval_ff}) ? IV_W'(trial - {1'b0, interval_ff})
                                                    : trial[IV_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      frame_in      = frame_ff;
      oid_in        = oid_ff;
      tid_in        = tid_ff;
      dt_in         = dt_ff;
      last_frame_in = last_frame_ff;
      cnt_this_in   = cnt_this_ff;
      cnt_last_in   = cnt_last_ff;
      crowded_in    = crowded_ff;
      interval_in   = interval_ff;
      mul_in        = mul_ff;
      slot_idx_in   = slot_idx_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      clr_in        = clr_ff;
      run_in        = run_ff;
      time_in       = time_ff;
      dec_in        = dec_ff;
      mem_we        = 1'b0;
      mem_waddr     = slot_idx_ff;
      mem_wdata     = '0;
      mem_raddr     = hash_idx;
      rd_en         = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in   = req_tdata[REQ_KEY_LSB +: KEY_W];
               frame_in = req_tdata[REQ_FRAME_LSB +: FRAME_W];
               oid_in   = req_tdata[REQ_OID_LSB +: ID_W];
               tid_in   = req_tdata[REQ_TID_LSB +: ID_W];
               dt_in    = req_tdata[REQ_DT_LSB +: DT_W];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            run_in  = 1'b1;
            time_in = TIME_W'(dt_ff);
            if (!key_valid) begin
               dec_in   = DEC_INVALID;
               state_in = S_OUT;
            end else begin
               last_frame_in = frame_ff;
               cnt_last_in   = cnt_last_new;
               crowded_in    = crowd_new;
               cnt_this_in   = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
               interval_in   = iv_eff;
               if (!crowd_new || is_target) begin
                  dec_in   = DEC_FULL;
                  state_in = S_OUT;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            mul_in   = product;
            state_in = S_READ;
         end
         S_READ: begin
            rd_en       = 1'b1;
            slot_idx_in = hash_idx;
            mul_in      = product;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (rd_ff.key != key_ff) begin
               num_in     = hash_idx;
               rem_in     = '0;
               bit_cnt_in = BIT_CNT_W'(SLOT_COUNT_LOG2 - 1);
               state_in   = S_MOD;
            end else if (gap >= FRAME_W'(interval_ff)) begin
               mem_we    = 1'b1;
               mem_wdata = '{key: key_ff, frame: frame_ff, banked: '0};
               run_in    = 1'b1;
               time_in   = bank_sat;
               dec_in    = DEC_DUE;
               state_in  = S_OUT;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = '{key: rd_ff.key, frame: rd_ff.frame, banked: bank_sat};
               run_in    = 1'b0;
               time_in   = '0;
               dec_in    = DEC_SKIP;
               state_in  = S_OUT;
            end
         end
         S_MOD: begin
            rem_in     = rem_step;
            num_in     = num_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               mem_we    = 1'b1;
               mem_wdata = '{key: key_ff, frame: frame_ff - FRAME_W'(rem_step), banked: '0};
               run_in    = 1'b1;
               time_in   = TIME_W'(dt_ff);
               dec_in    = DEC_FIRST;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_frame_ff <= '0;
         cnt_this_ff   <= '0;
         cnt_last_ff   <= '0;
         crowded_ff    <= 1'b0;
         clr_ff        <= '0;
      end else begin
         last_frame_ff <= last_frame_in;
         cnt_this_ff   <= cnt_this_in;
         cnt_last_ff   <= cnt_last_in;
         crowded_ff    <= crowded_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      frame_ff    <= frame_in;
      oid_ff      <= oid_in;
      tid_ff      <= tid_in;
      dt_ff       <= dt_in;
      interval_ff <= interval_in;
      mul_ff      <= mul_in;
      slot_idx_ff <= slot_idx_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      run_ff      <= run_in;
      time_ff     <= time_in;
      dec_ff      <= dec_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_ff <= slot_mem[mem_raddr];
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= CROWD_THRESHOLD_RST;
         heavy_cnt_ff <= HEAVY_CROWD_COUNT_RST;
         light_iv_ff  <= LIGHT_INTERVAL_RST;
         heavy_iv_ff  <= HEAVY_INTERVAL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CROWD_THRESHOLD:   thresh_ff    <= csr_data;
            CSR_HEAVY_CROWD_COUNT: heavy_cnt_ff <= csr_data;
            CSR_LIGHT_INTERVAL:    light_iv_ff  <= csr_data[IV_W-1:0];
            CSR_HEAVY_INTERVAL:    heavy_iv_ff  <= csr_data[IV_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_tdata = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), crowded_ff, dec_ff, time_ff, run_ff};

endmodule

`default_nettype wire

### rtl/hpout_checker.sv
// Port-level checker for the hashed per-object update throttle, and its bind.
// Uses hpout_pkg; attaches to hashed_per_object_update_throttle.
`default_nettype none

module hpout_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [hpout_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import hpout_pkg::*;

   logic [DEC_W-1:0] dec;
   logic             run;
   logic [TIME_W-1:0] upd_time;

   assign dec      = rsp_tdata[RSP_DEC_LSB +: DEC_W];
   assign run      = rsp_tdata[RSP_RUN_LSB];
   assign upd_time = rsp_tdata[RSP_TIME_LSB +: TIME_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_dec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> dec <= DEC_W'(DEC_SKIP))
      else $error("undefined decision code");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dec == DEC_W'(DEC_SKIP) |-> !run && upd_time == '0)
      else $error("skipped request runs or carries time");

   a_pass_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dec != DEC_W'(DEC_SKIP) |-> run)
      else $error("passed request does not run");

endmodule

bind hashed_per_object_update_throttle hpout_checker u_hpout_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for hashed_per_object_update_throttle.
// Drives update requests and register writes and checks every decision
// against an in-bench model; depends on rtl/hpout_pkg.sv and the top level.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hpout_pkg::*;

   localparam int SLOT_BITS   = SLOT_COUNT_LOG2_DEF;
   localparam int IDLE_PCT    = 8;
   localparam int HOLD_LEN    = 400;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int SAME_FRAME_BURST = 24;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [FRAME_W-1:0] frame;
      logic [ID_W-1:0]    oid;
      logic [ID_W-1:0]    tid;
      logic [DT_W-1:0]    dt;
   } upd_req_type;

   typedef struct packed {
      logic               run;
      logic [TIME_W-1:0]  utime;
      decision_type       dec;
      logic               crowded;
   } upd_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // model state
   logic [COUNT_W-1:0] thr_crowd, thr_heavy;
   logic [IV_W-1:0]    iv_light, iv_heavy;
   logic [FRAME_W-1:0] seen_frame;
   logic [COUNT_W-1:0] frame_requests, prior_requests;
   logic               crowd_on;
   logic [KEY_W-1:0]   tbl_key   [2**SLOT_BITS];
   logic [FRAME_W-1:0] tbl_frame [2**SLOT_BITS];
   logic [TIME_W-1:0]  tbl_bank  [2**SLOT_BITS];

   upd_req_type queued_updates [$];
   upd_rsp_type pending_decisions [$];
   upd_req_type held_update;
   upd_rsp_type drv_rsp, got_rsp, want_rsp;
   logic [REQ_TDATA_W-1:0] drv_tdata;

   int n_pushed = 0;
   int n_rsp = 0;
   int n_errors = 0;
   int n_csr = 0;
   int dec_seen [5] = '{default: 0};
   int cycle_count = 0;
   int hold_cycles = 0;
   logic quiet = 1'b0;
   logic hold_go = 1'b0;

   hashed_per_object_update_throttle u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [31:0] k);
      logic [31:0] m;
      m = k ^ (k >> 16);
      m = m * HASH_MULT;
      m = m ^ (m >> 15);
      return m[SLOT_BITS-1:0];
   endfunction

   function automatic upd_rsp_type throttle_decide(input upd_req_type r);
      upd_rsp_type o;
      logic [31:0] iv, phase;
      logic [SLOT_BITS-1:0] s;
      logic [TIME_W:0] sum;
      o.run = 1'b1;
      o.utime = {{(TIME_W-DT_W){1'b0}}, r.dt};
      o.dec = DEC_INVALID;
      o.crowded = crowd_on;
      if (r.key < KEY_LOW || r.key >= KEY_HIGH) return o;
      if (r.frame != seen_frame) begin
         prior_requests = frame_requests;
         frame_requests = '0;
         crowd_on = prior_requests >= thr_crowd;
         seen_frame = r.frame;
      end
      if (frame_requests != COUNT_MAX) frame_requests++;
      o.crowded = crowd_on;
      o.dec = DEC_FULL;
      if (!crowd_on || (r.oid != 0 && r.oid == r.tid)) return o;
      iv = 32'((prior_requests >= thr_heavy) ? iv_heavy : iv_light);
      if (iv == 0) iv = 1;
      s = slot_of(r.key);
      if (tbl_key[s] != r.key) begin
         phase = 32'(slot_of(~r.key)) % iv;
         tbl_key[s] = r.key;
         tbl_frame[s] = r.frame - phase;
         tbl_bank[s] = '0;
         o.dec = DEC_FIRST;
         return o;
      end
      sum = (TIME_W+1)'(tbl_bank[s]) + (TIME_W+1)'(r.dt);
      if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
      if (r.frame - tbl_frame[s] >= iv) begin
         tbl_frame[s] = r.frame;
         tbl_bank[s] = '0;
         o.utime = sum[TIME_W-1:0];
         o.dec = DEC_DUE;
      end else begin
         tbl_bank[s] = sum[TIME_W-1:0];
         o.run = 1'b0;
         o.utime = '0;
         o.dec = DEC_SKIP;
      end
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            drv_rsp = throttle_decide(held_update);
            pending_decisions.push_back(drv_rsp);
            dec_seen[int'(drv_rsp.dec)]++;
         end
         if (!req_tvalid || req_tready) begin
            if (queued_updates.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               held_update = queued_updates.pop_front();
               drv_tdata = '0;
               drv_tdata[REQ_KEY_LSB   +: KEY_W]   = held_update.key;
               drv_tdata[REQ_FRAME_LSB +: FRAME_W] = held_update.frame;
               drv_tdata[REQ_OID_LSB   +: ID_W]    = held_update.oid;
               drv_tdata[REQ_TID_LSB   +: ID_W]    = held_update.tid;
               drv_tdata[REQ_DT_LSB    +: DT_W]    = held_update.dt;
               req_tdata <= drv_tdata;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_go && hold_cycles < HOLD_LEN) begin
         hold_cycles++;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.run     = rsp_tdata[RSP_RUN_LSB];
         got_rsp.utime   = rsp_tdata[RSP_TIME_LSB +: TIME_W];
         got_rsp.dec     = decision_type'(rsp_tdata[RSP_DEC_LSB +: DEC_W]);
         got_rsp.crowded = rsp_tdata[RSP_CROWD_LSB];
         n_rsp++;
         if (pending_decisions.size() == 0) begin
            if (n_errors < 10)
               $display("ERROR: response %0d with no request pending: run=%0d time=%0h dec=%0d",
                        n_rsp, got_rsp.run, got_rsp.utime, got_rsp.dec);
            n_errors++;
         end else begin
            want_rsp = pending_decisions.pop_front();
            if (got_rsp.run !== want_rsp.run || got_rsp.utime !== want_rsp.utime ||
                got_rsp.dec !== want_rsp.dec || got_rsp.crowded !== want_rsp.crowded) begin
               if (n_errors < 10)
                  $display({"ERROR: response %0d exp run=%0d time=%0h dec=%0d crowd=%0d, ",
                            "got run=%0d time=%0h dec=%0d crowd=%0d"}, n_rsp,
                           want_rsp.run, want_rsp.utime, want_rsp.dec, want_rsp.crowded,
                           got_rsp.run, got_rsp.utime, got_rsp.dec, got_rsp.crowded);
               n_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d responses seen",
                  cycle_count, n_rsp, n_pushed);
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic push_update(input logic [31:0] k, input logic [31:0] f,
                              input logic [63:0] oid, input logic [63:0] tid,
                              input logic [19:0] dt);
      upd_req_type u;
      u.key = k;
      u.frame = f;
      u.oid = oid;
      u.tid = tid;
      u.dt = dt;
      queued_updates.push_back(u);
      n_pushed++;
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CROWD_THRESHOLD:   thr_crowd = val;
         CSR_HEAVY_CROWD_COUNT: thr_heavy = val;
         CSR_LIGHT_INTERVAL:    iv_light = val[IV_W-1:0];
         CSR_HEAVY_INTERVAL:    iv_heavy = val[IV_W-1:0];
      endcase
      n_csr++;
   endtask

   task automatic configure(input logic [15:0] thr, input logic [15:0] heavy,
                            input logic [15:0] lt, input logic [15:0] hv);
      set_reg(CSR_CROWD_THRESHOLD, thr);
      set_reg(CSR_HEAVY_CROWD_COUNT, heavy);
      set_reg(CSR_LIGHT_INTERVAL, lt);
      set_reg(CSR_HEAVY_INTERVAL, hv);
   endtask

   task automatic drain(input int settle);
      while (n_rsp < n_pushed) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [31:0] any_valid_key();
      return $urandom_range(32'hFFDF_FFFF, 32'h0001_0000);
   endfunction

   function automatic logic [31:0] collider_of(input logic [31:0] k);
      logic [31:0] c;
      do c = any_valid_key(); while (slot_of(c) != slot_of(k) || c == k);
      return c;
   endfunction

   function automatic logic [19:0] pick_dt();
      case ($urandom_range(9))
         0: return 20'hFFFFF;
         1: return 20'h0;
         2: return 20'($urandom);
         default: return 20'($urandom_range(33333, 8000));
      endcase
   endfunction

   // a scene: a pool of objects requesting once per frame, plus some noise
   task automatic gen_scene(input int n_obj, input int n_items, input logic [31:0] start_frame);
      logic [31:0] keys [$];
      logic [63:0] ids [$];
      logic [31:0] frame;
      logic [63:0] target;
      logic [19:0] dt;
      logic [31:0] bad_key;
      int made;
      made = 0;
      frame = start_frame;
      for (int i = 0; i < n_obj; i++) begin
         if (i > 0 && $urandom_range(4) == 0)
            keys.push_back(collider_of(keys[$urandom_range(i - 1)]));
         else
            keys.push_back(any_valid_key());
         ids.push_back(($urandom_range(9) == 0) ? 64'd0 : {$urandom, $urandom});
      end
      while (made < n_items) begin
         target = ($urandom_range(3) == 0) ? {$urandom, $urandom} : ids[$urandom_range(n_obj - 1)];
         dt = pick_dt();
         for (int i = 0; i < n_obj; i++) begin
            if ($urandom_range(99) < 90) begin
               push_update(keys[i], frame, ids[i], target, dt);
               made++;
            end
            if ($urandom_range(99) < 4) begin
               case ($urandom_range(2))
                  0: begin
                     bad_key = $urandom_range(1) ? $urandom_range(32'h0000_FFFF)
                                                 : $urandom_range(32'hFFFF_FFFF, 32'hFFE0_0000);
                     push_update(bad_key, $urandom, {$urandom, $urandom}, target, pick_dt());
                  end
                  1: push_update(any_valid_key(), frame, {$urandom, $urandom}, target, dt);
                  default: push_update(keys[i], frame - 1 - $urandom_range(3), ids[i], target, dt);
               endcase
            end
         end
         frame += ($urandom_range(9) == 0) ? $urandom_range(20, 2) : 1;
      end
   endtask

   initial begin
      logic [31:0] k_a, k_b, f_burst;
      logic [63:0] tgt;
      thr_crowd = CROWD_THRESHOLD_RST;
      thr_heavy = HEAVY_CROWD_COUNT_RST;
      iv_light = LIGHT_INTERVAL_RST;
      iv_heavy = HEAVY_INTERVAL_RST;
      seen_frame = '0;
      frame_requests = '0;
      prior_requests = '0;
      crowd_on = 1'b0;
      for (int i = 0; i < 2**SLOT_BITS; i++) begin
         tbl_key[i] = '0;
         tbl_frame[i] = '0;
         tbl_bank[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: window edges, frame 0 after reset, zero id, target,
      // bank saturation, zero interval, eviction
      set_reg(CSR_CROWD_THRESHOLD, 16'd2);
      set_reg(CSR_LIGHT_INTERVAL, 16'd0);
      k_a = 32'h1234_5000;
      k_b = collider_of(k_a);
      tgt = {$urandom, $urandom} | 64'd1;
      push_update(32'h0001_0000, 32'd0, 64'd1, 64'd2, 20'hFFFFF);
      push_update(32'hFFDF_FFFF, 32'd0, 64'd0, 64'd0, 20'h0);
      push_update(32'h0000_FFFF, 32'd0, 64'd5, 64'd5, 20'hFFFFF);
      push_update(32'hFFE0_0000, 32'd7, 64'd0, 64'd0, 20'h1);
      push_update(32'hFFFF_FFFF, 32'd0, '1, '1, 20'hFFFFF);
      push_update(k_a, 32'd1, 64'd0, 64'd0, 20'hFFFFF);
      push_update(32'h0002_0000, 32'd1, tgt, tgt, 20'd100);
      repeat (17) push_update(k_a, 32'd1, 64'd0, 64'd0, 20'hFFFFF);
      push_update(k_a, 32'd2, 64'd0, 64'd0, 20'hFFFFF);
      push_update(k_b, 32'd2, 64'd0, 64'd0, 20'd10);
      push_update(k_a, 32'd2, 64'd0, 64'd0, 20'd10);
      drain(20);

      // reset-like settings, with the receiver holding off
      configure(16'd8, 16'd20, 16'd2, 16'd3);
      gen_scene(20, 160, $urandom);
      @(negedge clock);
      hold_go = 1'b1;
      drain(20);

      // always crowded and always heavy
      configure(16'd0, 16'd0, 16'd1, 16'd15);
      gen_scene(16, 140, 32'hFFFF_FFFF - $urandom_range(6));
      drain(20);

      // same-frame burst of new keys, no idling on either side
      configure(16'hFFFF, 16'hFFFF, 16'd15, 16'd0);
      quiet = 1'b1;
      f_burst = $urandom;
      repeat (SAME_FRAME_BURST) push_update(any_valid_key(), f_burst, {$urandom, $urandom},
                                            {$urandom, $urandom}, pick_dt());
      gen_scene(12, 60, f_burst + 1);
      drain(20);
      quiet = 1'b0;

      repeat (3) begin
         configure(16'($urandom_range(30, 1)), 16'($urandom_range(40, 5)),
                   16'($urandom_range(15, 0)), 16'($urandom_range(15, 0)));
         gen_scene($urandom_range(30, 8), 100, $urandom);
         drain(20);
      end

      drain(40);
      if (pending_decisions.size() != 0) begin
         $display("ERROR: %0d decisions never arrived", pending_decisions.size());
         n_errors += pending_decisions.size();
      end
      $display({"%0d requests over %0d register writes: invalid %0d, full %0d, ",
                "first %0d, due %0d, skip %0d"},
               n_rsp, n_csr, dec_seen[0], dec_seen[1], dec_seen[2], dec_seen[3], dec_seen[4]);
      $display("same-frame burst and %0d-cycle output hold-off done, %0d errors",
               hold_cycles, n_errors);
      if (n_errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
rtl/hpout_pkg.sv
rtl/hashed_per_object_update_throttle.sv
rtl/hpout_checker.sv
tb/tb_top.sv
